// File: rtl/nft_pkg.sv
// ----------------------------------------------------------------------------
// nft_pkg: shared types and constants of the NAT flow translation core
// Item layouts, table entry layout, status codes, register indexes, states.
// ----------------------------------------------------------------------------
`default_nettype none
package nft_pkg;

  localparam int FLOW_ENTRIES = 64;

  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [16:0] ETH_HDR_LEN = 17'd14;
  localparam logic [6:0]  TCP_HDR_LEN = 7'd20;
  localparam logic [6:0]  UDP_HDR_LEN = 7'd8;
  localparam logic [3:0]  TCP_MIN_OFF = 4'd5;
  localparam logic [15:0] UDP_MIN_LEN = 16'd8;

  localparam logic [2:0] ST_FORWARD  = 3'd0;
  localparam logic [2:0] ST_NOT_IPV4 = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_BAD_PROT = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [2:0] REG_NAT_ADDR  = 3'd0;
  localparam logic [2:0] REG_P0_OWN    = 3'd1;
  localparam logic [2:0] REG_P1_OWN    = 3'd2;
  localparam logic [2:0] REG_P0_PEER   = 3'd3;
  localparam logic [2:0] REG_P1_PEER   = 3'd4;

  typedef struct packed {
    logic        in_port;
    logic        is_ipv4;
    logic [7:0]  protocol;
    logic [3:0]  header_words;
    logic [15:0] frame_len;
    logic [15:0] ip_total_len;
    logic [3:0]  tcp_offset;
    logic [15:0] udp_len;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        out_port;
    logic        new_flow;
    logic [31:0] new_src_ip;
    logic [31:0] new_dst_ip;
    logic [15:0] new_src_port;
    logic [15:0] new_dst_port;
    logic [47:0] new_src_mac;
    logic [47:0] new_dst_mac;
  } out_item_t;

  typedef struct packed {
    logic [63:0] addrs;
    logic [31:0] ports;
  } val_t;

  typedef struct packed {
    logic [63:0] key_addrs;
    logic [39:0] key_pp;
    val_t        value;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_LOOK, S_FREE1, S_FREE2, S_PROBE, S_INS, S_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/nft_if.sv
// ----------------------------------------------------------------------------
// nft_in_if / nft_out_if: valid/ready channels of the core
// One interface for packet headers in, one for translation results out.
// ----------------------------------------------------------------------------
`default_nettype none
interface nft_in_if;
  logic              valid;
  logic              ready;
  nft_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nft_out_if;
  logic               valid;
  logic               ready;
  nft_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/nat_flow_translation_core.sv
// ----------------------------------------------------------------------------
// nat_flow_translation_core: NAT/PAT translator with exact-match flow table
// Validates parsed headers, looks the 5-tuple up in a row of entry cells,
// allocates an external port and two entries for new outbound flows.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_chan  | in  | valid/ready   | parsed header fields (in_item_t)
//  out_chan | out | valid/ready   | status and rewritten fields (out_item_t)
//  cfg_*    | in  | cfg_we only   | register index, 48-bit write data
//
//  Packets failing the header checks pass S_CHECK to S_EMIT, known flows and
//  unknown inbound go on through S_LOOK, a full table through S_FREE1 and
//  S_FREE2, new flows on through S_PROBE, which repeats once per occupied
//  external port skipped (a single-query compare across the cell row), and S_INS.
//  Reset (rst_n low, synchronous) empties the table and clears the configuration registers.
//  A new header is taken while a result still waits on out_chan; the
//  next result waits in S_EMIT until the output register is free.
`default_nettype none
module nat_flow_translation_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  nft_in_if.sink           in_chan,
  nft_out_if.source        out_chan,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  localparam int N = nft_pkg::FLOW_ENTRIES;

  // configuration registers
  logic [31:0] nat_addr_r;
  logic [47:0] p0_own_r, p1_own_r, p0_peer_r, p1_peer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nat_addr_r <= '0;
      p0_own_r   <= '0;
      p1_own_r   <= '0;
      p0_peer_r  <= '0;
      p1_peer_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nft_pkg::REG_NAT_ADDR: nat_addr_r <= cfg_data[31:0];
        nft_pkg::REG_P0_OWN:   p0_own_r   <= cfg_data;
        nft_pkg::REG_P1_OWN:   p1_own_r   <= cfg_data;
        nft_pkg::REG_P0_PEER:  p0_peer_r  <= cfg_data;
        nft_pkg::REG_P1_PEER:  p1_peer_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  nft_pkg::state_t    state_r, state_nxt;
  nft_pkg::in_item_t  item_r;
  nft_pkg::out_item_t res_r, res_nxt;
  nft_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic [N-1:0]       slot1_r, slot1_nxt, slot2_r, slot2_nxt;
  logic [15:0]        xp_r, xp_nxt;

  // cell row
  logic [63:0]     q_addrs;
  logic [39:0]     q_pp;
  logic [N:0]      hit_c;
  nft_pkg::val_t   acc_c [N+1];
  logic [N-1:0]    match_v, valid_v, we_v;
  nft_pkg::entry_t e_out, e_ret;

  // lookup query: the packet key, or the return key under probe
  always_comb begin
    if (state_r == nft_pkg::S_PROBE) begin
      q_addrs = {item_r.dst_ip, nat_addr_r};
      q_pp    = {item_r.protocol, item_r.dport, xp_r};
    end else begin
      q_addrs = {item_r.src_ip, item_r.dst_ip};
      q_pp    = {item_r.protocol, item_r.sport, item_r.dport};
    end
  end

  assign e_out.key_addrs    = {item_r.src_ip, item_r.dst_ip};
  assign e_out.key_pp       = {item_r.protocol, item_r.sport, item_r.dport};
  assign e_out.value.addrs  = {nat_addr_r, item_r.dst_ip};
  assign e_out.value.ports  = {xp_r, item_r.dport};
  assign e_ret.key_addrs    = {item_r.dst_ip, nat_addr_r};
  assign e_ret.key_pp       = {item_r.protocol, item_r.dport, xp_r};
  assign e_ret.value.addrs  = {item_r.dst_ip, item_r.src_ip};
  assign e_ret.value.ports  = {item_r.dport, item_r.sport};

  assign hit_c[0] = 1'b0;
  assign acc_c[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign we_v[i] = (state_r == nft_pkg::S_INS) && (slot1_r[i] || slot2_r[i]);
    nft_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .q_addrs (q_addrs),
      .q_pp    (q_pp),
      .we      (we_v[i]),
      .wdata   (slot1_r[i] ? e_out : e_ret),
      .hit_in  (hit_c[i]),
      .acc_in  (acc_c[i]),
      .hit_out (hit_c[i+1]),
      .acc_out (acc_c[i+1]),
      .match   (match_v[i]),
      .valid   (valid_v[i])
    );
  end

  // truncation thresholds; 4*IHL plus transport header fits 7 bits
  logic        is_tcp, is_udp, trunc;
  logic [6:0]  ip_min;
  logic [N-1:0] free_v, free2_v;

  assign is_tcp  = item_r.protocol == nft_pkg::PROTO_TCP;
  assign is_udp  = item_r.protocol == nft_pkg::PROTO_UDP;
  assign ip_min  = {1'b0, item_r.header_words, 2'b00} +
                   (is_tcp ? nft_pkg::TCP_HDR_LEN : nft_pkg::UDP_HDR_LEN);
  assign trunc   = ({1'b0, item_r.frame_len} < (nft_pkg::ETH_HDR_LEN + {10'd0, ip_min})) ||
                   (item_r.ip_total_len < {9'd0, ip_min}) ||
                   (is_tcp && (item_r.tcp_offset < nft_pkg::TCP_MIN_OFF)) ||
                   (is_udp && (item_r.udp_len < nft_pkg::UDP_MIN_LEN));
  // free slot masks; the lowest free slot is picked as one-hot with x & -x
  assign free_v  = ~valid_v;
  assign free2_v = free_v & ~slot1_r;

  logic out_free;
  assign out_free = !out_valid_r || out_chan.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nft_pkg::S_IDLE:  if (in_chan.valid) state_nxt = nft_pkg::S_CHECK;
      nft_pkg::S_CHECK: begin
        if (!item_r.is_ipv4 || !(is_tcp || is_udp) || trunc) state_nxt = nft_pkg::S_EMIT;
        else state_nxt = nft_pkg::S_LOOK;
      end
      nft_pkg::S_LOOK: begin
        if (hit_c[N] || item_r.dst_ip == nat_addr_r) state_nxt = nft_pkg::S_EMIT;
        else state_nxt = nft_pkg::S_FREE1;
      end
      nft_pkg::S_FREE1: state_nxt = nft_pkg::S_FREE2;
      nft_pkg::S_FREE2: begin
        if (free2_v == '0) state_nxt = nft_pkg::S_EMIT;
        else state_nxt = nft_pkg::S_PROBE;
      end
      nft_pkg::S_PROBE: if (!hit_c[N]) state_nxt = nft_pkg::S_INS;
      nft_pkg::S_INS:   state_nxt = nft_pkg::S_EMIT;
      nft_pkg::S_EMIT:  if (out_free) state_nxt = nft_pkg::S_IDLE;
      default:          state_nxt = nft_pkg::S_IDLE;
    endcase
  end

  // result assembly
  function automatic nft_pkg::out_item_t fwd(nft_pkg::in_item_t it, nft_pkg::val_t v,
                                             logic nf, logic [47:0] o0, logic [47:0] o1,
                                             logic [47:0] e0, logic [47:0] e1);
    nft_pkg::out_item_t r;
    r.status       = nft_pkg::ST_FORWARD;
    r.out_port     = ~it.in_port;
    r.new_flow     = nf;
    r.new_src_ip   = v.addrs[63:32];
    r.new_dst_ip   = v.addrs[31:0];
    r.new_src_port = v.ports[31:16];
    r.new_dst_port = v.ports[15:0];
    r.new_src_mac  = it.in_port ? o0 : o1;
    r.new_dst_mac  = it.in_port ? e0 : e1;
    return r;
  endfunction

  always_comb begin
    res_nxt   = res_r;
    slot1_nxt = slot1_r;
    slot2_nxt = slot2_r;
    xp_nxt    = xp_r;
    unique case (state_r)
      nft_pkg::S_CHECK: begin
        res_nxt.status       = nft_pkg::ST_FORWARD;
        res_nxt.out_port     = item_r.in_port;
        res_nxt.new_flow     = 1'b0;
        res_nxt.new_src_ip   = item_r.src_ip;
        res_nxt.new_dst_ip   = item_r.dst_ip;
        res_nxt.new_src_port = item_r.sport;
        res_nxt.new_dst_port = item_r.dport;
        res_nxt.new_src_mac  = '0;
        res_nxt.new_dst_mac  = '0;
        if (!item_r.is_ipv4)           res_nxt.status = nft_pkg::ST_NOT_IPV4;
        else if (!(is_tcp || is_udp))  res_nxt.status = nft_pkg::ST_BAD_PROT;
        else if (trunc)                res_nxt.status = nft_pkg::ST_TRUNC;
      end
      nft_pkg::S_LOOK: begin
        if (hit_c[N]) begin
          res_nxt = fwd(item_r, acc_c[N], 1'b0, p0_own_r, p1_own_r, p0_peer_r, p1_peer_r);
        end else if (item_r.dst_ip == nat_addr_r) begin
          res_nxt.status = nft_pkg::ST_UNKNOWN;
        end
      end
      nft_pkg::S_FREE1: slot1_nxt = free_v & (~free_v + 1'b1);
      nft_pkg::S_FREE2: begin
        slot2_nxt = free2_v & (~free2_v + 1'b1);
        xp_nxt    = item_r.sport;
        if (free2_v == '0) res_nxt.status = nft_pkg::ST_FULL;
      end
      nft_pkg::S_PROBE: if (hit_c[N]) xp_nxt = xp_r + 16'd1;
      nft_pkg::S_INS: begin
        res_nxt = fwd(item_r, e_out.value, 1'b1, p0_own_r, p1_own_r, p0_peer_r, p1_peer_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nft_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      slot1_r     <= '0;
      slot2_r     <= '0;
    end else begin
      state_r <= state_nxt;
      slot1_r <= slot1_nxt;
      slot2_r <= slot2_nxt;
      if (state_r == nft_pkg::S_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    xp_r  <= xp_nxt;
    if (state_r == nft_pkg::S_IDLE && in_chan.valid) item_r <= in_chan.data;
    if (state_r == nft_pkg::S_EMIT && out_free) out_data_r <= res_r;
  end

  assign in_chan.ready  = state_r == nft_pkg::S_IDLE;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // a key lives in at most one entry
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_v)) else $error("duplicate key in flow table");
  // insertion writes two distinct free slots
  a_ins_slots: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nft_pkg::S_INS |-> $onehot(slot1_r) && $onehot(slot2_r) &&
    ((slot1_r & slot2_r) == '0) && ((valid_v & (slot1_r | slot2_r)) == '0))
    else $error("bad insertion slots");
  // a new flow leaves exactly two more valid entries
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nft_pkg::S_INS |=> $countones(valid_v) == $countones($past(valid_v)) + 2)
    else $error("insert did not add two entries");
  // the output register is never overwritten while it still holds a result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(out_data_r))
    else $error("result overwritten");
endmodule
`default_nettype wire

// File: rtl/nft_cell.sv
// ----------------------------------------------------------------------------
// nft_cell: one flow table entry
// Holds key and value, compares against the broadcast query and folds its
// hit and value into the chain from its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none
module nft_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [63:0]    q_addrs,
  input  wire logic [39:0]    q_pp,
  input  wire logic           we,
  input  wire nft_pkg::entry_t wdata,
  input  wire logic           hit_in,
  input  wire nft_pkg::val_t  acc_in,
  output logic                hit_out,
  output nft_pkg::val_t       acc_out,
  output logic                match,
  output logic                valid
);
  logic            valid_r;
  nft_pkg::entry_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (we) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ent_r <= wdata;
    end
  end

  assign match   = valid_r && (ent_r.key_addrs == q_addrs) && (ent_r.key_pp == q_pp);
  assign hit_out = hit_in | match;
  assign acc_out = acc_in | (match ? ent_r.value : '0);
  assign valid   = valid_r;
endmodule
`default_nettype wire

// File: sim/nft_checker.sv
// ----------------------------------------------------------------------------
// nft_checker: flow table predictor and result scoreboard
// Watches both channels and the register port, predicts each translation
// result in order and compares it field by field with what the core emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nft_checker
  import nft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [31:0] nat_addr;
  logic [47:0] own_mac [2];
  logic [47:0] peer_mac [2];
  logic        slot_used [FLOW_ENTRIES];
  entry_t      slot [FLOW_ENTRIES];
  out_item_t   expected_results [$];

  assign pending = expected_results.size();

  function automatic int lookup_flow(logic [63:0] ka, logic [39:0] kp);
    for (int i = 0; i < FLOW_ENTRIES; i++)
      if (slot_used[i] && slot[i].key_addrs == ka && slot[i].key_pp == kp) return i;
    return -1;
  endfunction

  function automatic out_item_t translate(in_item_t p);
    out_item_t r;
    logic [6:0]  thdr;
    logic [63:0] ka, ra;
    logic [39:0] kp;
    val_t        v;
    int          hit, s1, s2;
    logic [15:0] xp;
    r = '0;
    r.status = ST_FORWARD;
    r.out_port = p.in_port;
    r.new_src_ip = p.src_ip;
    r.new_dst_ip = p.dst_ip;
    r.new_src_port = p.sport;
    r.new_dst_port = p.dport;
    if (!p.is_ipv4) begin
      r.status = ST_NOT_IPV4;
    end else if (p.protocol != PROTO_TCP && p.protocol != PROTO_UDP) begin
      r.status = ST_BAD_PROT;
    end else begin
      thdr = (p.protocol == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
      if (32'(p.frame_len) < 14 + 4 * 32'(p.header_words) + 32'(thdr) ||
          32'(p.ip_total_len) < 4 * 32'(p.header_words) + 32'(thdr) ||
          (p.protocol == PROTO_TCP && p.tcp_offset < TCP_MIN_OFF) ||
          (p.protocol == PROTO_UDP && p.udp_len < UDP_MIN_LEN))
        r.status = ST_TRUNC;
    end
    if (r.status != ST_FORWARD) return r;
    ka = {p.src_ip, p.dst_ip};
    kp = {p.protocol, p.sport, p.dport};
    hit = lookup_flow(ka, kp);
    if (hit >= 0) begin
      v = slot[hit].value;
    end else if (p.dst_ip == nat_addr) begin
      r.status = ST_UNKNOWN;
      return r;
    end else begin
      s1 = -1;
      s2 = -1;
      for (int i = 0; i < FLOW_ENTRIES; i++)
        if (!slot_used[i]) begin
          if (s1 < 0) s1 = i;
          else if (s2 < 0) s2 = i;
        end
      if (s2 < 0) begin
        r.status = ST_FULL;
        return r;
      end
      ra = {p.dst_ip, nat_addr};
      xp = p.sport;
      while (lookup_flow(ra, {p.protocol, p.dport, xp}) >= 0) xp++;
      v.addrs = {nat_addr, p.dst_ip};
      v.ports = {xp, p.dport};
      slot_used[s1] = 1'b1;
      slot[s1] = '{ka, kp, v};
      slot_used[s2] = 1'b1;
      slot[s2] = '{ra, {p.protocol, p.dport, xp},
                   '{{p.dst_ip, p.src_ip}, {p.dport, p.sport}}};
      r.new_flow = 1'b1;
    end
    r.out_port = ~p.in_port;
    {r.new_src_ip, r.new_dst_ip} = v.addrs;
    {r.new_src_port, r.new_dst_port} = v.ports;
    r.new_src_mac = own_mac[r.out_port];
    r.new_dst_mac = peer_mac[r.out_port];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      nat_addr <= '0;
      own_mac <= '{default: '0};
      peer_mac <= '{default: '0};
      for (int i = 0; i < FLOW_ENTRIES; i++) slot_used[i] = 1'b0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NAT_ADDR: nat_addr <= cfg_data[31:0];
          REG_P0_OWN:   own_mac[0] <= cfg_data;
          REG_P1_OWN:   own_mac[1] <= cfg_data;
          REG_P0_PEER:  peer_mac[0] <= cfg_data;
          REG_P1_PEER:  peer_mac[1] <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(translate(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: sim/nat_flow_translation_core_tb.sv
// ----------------------------------------------------------------------------
// nat_flow_translation_core_tb: stimulus and verdict for the NAT core
// Drives header transfers with random gaps and output stalls across several
// register settings; the checker predicts and scores every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nat_flow_translation_core_tb;
  import nft_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  int          fail_count;
  int          pending;
  bit          no_gaps;     // burst phase: neither side idles
  bit          long_hold;   // sink holds off to back the core up

  nft_in_if  in_chan ();
  nft_out_if out_chan ();

  nat_flow_translation_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  nft_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_data   (in_chan.data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sink side: ~38% stall, none in burst phase, plus one long hold-off.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_chan.ready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end
      out_chan.ready <= no_gaps || ($urandom_range(99) >= 38);
    end
  end

  // Small pools of endpoints so flows repeat, hit, and fill the table.
  logic [31:0] nat_ip;
  logic [31:0] inside_ip [4];
  logic [31:0] outside_ip [4];

  function automatic in_item_t noise_item();
    in_item_t p;
    p = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return p;
  endfunction

  // Well-formed TCP/UDP header with lengths at or above the minimum.
  function automatic in_item_t good_item(bit outbound);
    in_item_t p;
    p = noise_item();
    p.is_ipv4 = 1'b1;
    p.protocol = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
    p.header_words = 4'($urandom_range(15, 5));
    p.frame_len = 16'(14 + 4 * p.header_words + 20 + $urandom_range(1500));
    p.ip_total_len = 16'(4 * p.header_words + 20 + $urandom_range(1500));
    p.tcp_offset = 4'($urandom_range(15, 5));
    p.udp_len = 16'($urandom_range(65535, 8));
    p.sport = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(1027, 1024));
    p.dport = $urandom_range(1) ? 16'd80 : 16'd53;
    if (outbound) begin
      p.src_ip = inside_ip[2'($urandom_range(3))];
      p.dst_ip = outside_ip[2'($urandom_range(3))];
    end else begin
      p.src_ip = outside_ip[2'($urandom_range(3))];
      p.dst_ip = nat_ip;
    end
    return p;
  endfunction

  task automatic send(in_item_t p);
    while (!no_gaps && $urandom_range(99) < 38) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= p;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic configure(logic [47:0] nat, logic [47:0] mac_seed);
    nat_ip = nat[31:0];
    write_reg(REG_NAT_ADDR, nat);
    write_reg(REG_P0_OWN, mac_seed);
    write_reg(REG_P1_OWN, ~mac_seed);
    write_reg(REG_P0_PEER, {mac_seed[23:0], mac_seed[47:24]});
    write_reg(REG_P1_PEER, mac_seed ^ 48'h5A5A_A5A5_0F0F);
  endtask

  task automatic directed();
    in_item_t p;
    p = good_item(1);
    p.is_ipv4 = 1'b0;
    send(p);                                     // not IPv4
    p = good_item(1);
    p.protocol = 8'd1;
    send(p);                                     // unsupported protocol
    p.protocol = 8'hFF;
    send(p);
    p = good_item(1);
    p.protocol = PROTO_TCP;
    p.header_words = 4'd5;
    p.frame_len = 16'd53;
    send(p);                                     // frame one byte short
    p.frame_len = 16'd54;
    p.ip_total_len = 16'd39;
    send(p);                                     // total length short
    p.ip_total_len = 16'd40;
    p.tcp_offset = 4'd4;
    send(p);                                     // data offset short
    p.tcp_offset = 4'd5;
    send(p);                                     // exactly minimal: new flow
    send(p);                                     // same flow hits
    p.protocol = PROTO_UDP;
    p.frame_len = 16'd42;
    p.ip_total_len = 16'd28;
    p.udp_len = 16'd7;
    send(p);                                     // UDP length short
    p.udp_len = 16'd8;
    p.in_port = ~p.in_port;
    send(p);
    p.header_words = 4'd15;
    p.frame_len = 16'hFFFF;
    p.ip_total_len = 16'hFFFF;
    p.udp_len = 16'hFFFF;
    p.sport = 16'hFFFF;
    send(p);                                     // probe start at top port
    p = good_item(0);
    send(p);                                     // unknown inbound
    p = good_item(1);
    p.header_words = 4'd0;
    p.frame_len = 16'd0;
    send(p);
    p = noise_item();
    p.frame_len = '0;
    send(p);
  endtask

  task automatic random_phase(int n);
    in_item_t p;
    int       k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 15) p = noise_item();
      else if (k < 30) p = good_item(0);
      else p = good_item(1);
      if (k >= 95) p.header_words = 4'($urandom_range(4)); // short header, odd lengths
      send(p);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    no_gaps = 1'b0;
    long_hold = 1'b0;
    nat_ip = '0;
    foreach (inside_ip[i]) inside_ip[i] = {8'd10, 24'($urandom)};
    foreach (outside_ip[i]) outside_ip[i] = $urandom;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers first, then extremes, then random settings.
    directed();
    drain();
    configure(48'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    outside_ip[0] = 32'h0;
    directed();
    random_phase(120);
    drain();

    configure(48'h0, 48'h0);
    long_hold = 1'b1;                            // back up the whole pipe
    random_phase(40);
    no_gaps = 1'b1;                              // gap-free burst
    random_phase(60);
    no_gaps = 1'b0;
    drain();

    configure({16'h0, $urandom}, {$urandom, 16'($urandom)});
    random_phase(250);
    drain();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: nat_flow_translation_core.f
rtl/nft_pkg.sv
rtl/nft_if.sv
rtl/nft_cell.sv
rtl/nat_flow_translation_core.sv
sim/nft_checker.sv
sim/nat_flow_translation_core_tb.sv
